>>> rtl/psc_pkg.sv
// Shared types and constants for the PID speed controller.
// Used by the other files of the block but psc_checker; depends on nothing.
package psc_pkg;

  // Default width of speed samples and of the setpoint.
  localparam int SPEED_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int GAIN_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int DRIVE_W    = 16;
  localparam int REG_IDX_W  = 3;
  localparam int INTEG_W    = 48;
  localparam int INTEG_HALF = 24;
  localparam int DERIV_W    = 32;
  localparam int FRAC_GAIN  = 8;
  localparam int FRAC_TIME  = 16;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'h0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd66;
  localparam logic [DRIVE_W-1:0]  DRIVE_MIN_RST = 16'h8000;
  localparam logic [DRIVE_W-1:0]  DRIVE_MAX_RST = 16'h7FFF;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_TARGET_SPEED  = 3'd3,
    REG_SAMPLE_PERIOD = 3'd4,
    REG_DRIVE_MIN     = 3'd5,
    REG_DRIVE_MAX     = 3'd6
  } psc_reg_e;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_ERR_PERIOD,
    MUL_KP,
    MUL_KI_LO,
    MUL_KI_HI,
    MUL_KD
  } mul_sel_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_start;
    mul_sel_e mul_sel;
    logic     int_upd;
    logic     acc_init;
    logic     tmp_load;
    logic     tmp_add;
    logic     acc_add_tmp;
    logic     deriv_load;
    logic     acc_add_prod;
    logic     out_load;
  } psc_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic div_busy;
  } psc_status_t;

endpackage

>>> rtl/psc_intf.sv
// Channel interfaces of the PID speed controller: sample, result, config write.
// Depends on psc_pkg.
interface psc_sample_if import psc_pkg::*; #(
  parameter int Width = SPEED_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [Width-1:0] measured_speed;

  modport source (output valid, output measured_speed, input ready);
  modport sink   (input valid, input measured_speed, output ready);
endinterface

interface psc_result_if import psc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface psc_cfg_if import psc_pkg::*; #(
  parameter int DataWidth = GAIN_W
);
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [DataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/psc_regs.sv
// Configuration register file of the PID speed controller.
// Depends on psc_pkg and psc_cfg_if.
module psc_regs import psc_pkg::*; #(
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
  parameter int CFG_WIDTH   = GAIN_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  psc_cfg_if.sink                       cfg_i,
  output logic signed [GAIN_W-1:0]      gain_p_o,
  output logic signed [GAIN_W-1:0]      gain_i_o,
  output logic signed [GAIN_W-1:0]      gain_d_o,
  output logic signed [SPEED_WIDTH-1:0] target_speed_o,
  output logic [PERIOD_W-1:0]           sample_period_o,
  output logic signed [DRIVE_W-1:0]     drive_min_o,
  output logic signed [DRIVE_W-1:0]     drive_max_o
);

  logic signed [GAIN_W-1:0]      gain_p_q, gain_i_q, gain_d_q;
  logic signed [SPEED_WIDTH-1:0] target_q;
  logic [PERIOD_W-1:0]           period_q;
  logic signed [DRIVE_W-1:0]     dmin_q, dmax_q;
  logic [CFG_WIDTH-1:0]          wdata;

  assign cfg_i.ready = 1'b1;
  assign wdata       = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_RST;
      gain_i_q <= GAIN_RST;
      gain_d_q <= GAIN_RST;
      target_q <= '0;
      period_q <= PERIOD_RST;
      dmin_q   <= DRIVE_MIN_RST;
      dmax_q   <= DRIVE_MAX_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (psc_reg_e'(cfg_i.index))
        REG_GAIN_P:        gain_p_q <= wdata[GAIN_W-1:0];
        REG_GAIN_I:        gain_i_q <= wdata[GAIN_W-1:0];
        REG_GAIN_D:        gain_d_q <= wdata[GAIN_W-1:0];
        REG_TARGET_SPEED:  target_q <= wdata[SPEED_WIDTH-1:0];
        REG_SAMPLE_PERIOD: period_q <= wdata[PERIOD_W-1:0];
        REG_DRIVE_MIN:     dmin_q   <= wdata[DRIVE_W-1:0];
        REG_DRIVE_MAX:     dmax_q   <= wdata[DRIVE_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  assign gain_p_o        = gain_p_q;
  assign gain_i_o        = gain_i_q;
  assign gain_d_o        = gain_d_q;
  assign target_speed_o  = target_q;
  assign sample_period_o = period_q;
  assign drive_min_o     = dmin_q;
  assign drive_max_o     = dmax_q;

endmodule

>>> rtl/psc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on psc_pkg.
module psc_div import psc_pkg::*; #(
  parameter int DIVIDEND_W = SPEED_WIDTH_DEF + 18,
  parameter int DIVISOR_W  = PERIOD_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  sub;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign sub     = {1'b0, shifted} - {2'b00, divisor_i};
  assign ge      = !sub[DIVISOR_W+1];
  assign rem_d   = ge ? sub[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  assign quo_d   = {quo_q[DIVIDEND_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DIVIDEND_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

>>> rtl/psc_datapath.sv
// Datapath of the PID speed controller: error, integral, shared multiplier,
// accumulator, derivative divider and output clamp. Depends on psc_pkg, psc_div.
module psc_datapath import psc_pkg::*; #(
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psc_cmd_t                      cmd_i,
  output psc_status_t                   status_o,
  input  logic signed [SPEED_WIDTH-1:0] measured_speed_i,
  input  logic signed [GAIN_W-1:0]      gain_p_i,
  input  logic signed [GAIN_W-1:0]      gain_i_i,
  input  logic signed [GAIN_W-1:0]      gain_d_i,
  input  logic signed [SPEED_WIDTH-1:0] target_speed_i,
  input  logic [PERIOD_W-1:0]           sample_period_i,
  input  logic signed [DRIVE_W-1:0]     drive_min_i,
  input  logic signed [DRIVE_W-1:0]     drive_max_i,
  output logic signed [DRIVE_W-1:0]     drive_o,
  output logic                          clamped_o
);

  localparam int EW  = SPEED_WIDTH + 1;
  localparam int DW  = EW + 1 + FRAC_TIME;
  localparam int MAW = (EW > DERIV_W) ? EW : DERIV_W;
  localparam int MBW = GAIN_W + 1;
  localparam int PW  = MAW + MBW;
  localparam int ACW = ((EW + GAIN_W > INTEG_W) ? EW + GAIN_W : INTEG_W) + 2;
  localparam int TW  = 64;
  localparam int ISW = ((PW > INTEG_W) ? PW : INTEG_W) + 1;
  localparam int QW  = ((DW > DERIV_W) ? DW : DERIV_W) + 1;

  localparam logic signed [ISW-1:0] IntegMax = $signed(ISW'({1'b0, {(INTEG_W-1){1'b1}}}));
  localparam logic signed [ISW-1:0] IntegMin = -IntegMax - ISW'(1);
  localparam logic [QW-1:0]         DerivPos = QW'({1'b0, {(DERIV_W-1){1'b1}}});
  localparam logic [QW-1:0]         DerivNeg = DerivPos + QW'(1);

  // State and working registers
  logic signed [EW-1:0]      error_q, last_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [PW-1:0]      prod_q;
  logic signed [ACW-1:0]     acc_q;
  logic signed [TW-1:0]      tmp_q;
  logic signed [DERIV_W-1:0] deriv_q, deriv_d;
  logic                      div_neg_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      clamped_q;

  logic [PERIOD_W-1:0]   period_eff;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [ISW-1:0] isum;
  logic signed [EW:0]    diff;
  logic [EW:0]           diff_mag;
  logic [DW-1:0]         dividend;
  logic [DW-1:0]         quotient;
  logic [QW-1:0]         qx;
  logic                  div_busy;
  logic signed [ACW-1:0] u_full, lo_ext, hi_ext;
  logic signed [DRIVE_W-1:0] drive_d;
  logic                  clamped_d;

  // A zero period acts as one
  assign period_eff = (sample_period_i == '0) ? PERIOD_W'(1) : sample_period_i;

  // Shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ERR_PERIOD: begin
        mul_a = MAW'(error_q);
        mul_b = $signed({1'b0, period_eff});
      end
      MUL_KP: begin
        mul_a = MAW'(error_q);
        mul_b = MBW'(gain_p_i);
      end
      MUL_KI_LO: begin
        mul_a = MAW'($signed({1'b0, integ_q[INTEG_HALF-1:0]}));
        mul_b = MBW'(gain_i_i);
      end
      MUL_KI_HI: begin
        mul_a = MAW'($signed(integ_q[INTEG_W-1:INTEG_HALF]));
        mul_b = MBW'(gain_i_i);
      end
      MUL_KD: begin
        mul_a = MAW'(deriv_q);
        mul_b = MBW'(gain_d_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating integral update
  assign isum = ISW'(integ_q) + ISW'(prod_q);

  // Derivative dividend: |error - last_error| scaled by 2^16
  assign diff     = (EW+1)'(error_q) - (EW+1)'(last_q);
  assign diff_mag = diff[EW] ? (EW+1)'(-diff) : (EW+1)'(diff);
  assign dividend = {diff_mag, {FRAC_TIME{1'b0}}};

  psc_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (PERIOD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (period_eff),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign status_o.div_busy = div_busy;

  // Restore sign and saturate the quotient to 32 bits
  assign qx = QW'(quotient);
  always_comb begin
    if (div_neg_q) begin
      if (qx > DerivNeg) deriv_d = $signed({1'b1, {(DERIV_W-1){1'b0}}});
      else               deriv_d = DERIV_W'(0) - qx[DERIV_W-1:0];
    end else begin
      if (qx > DerivPos) deriv_d = $signed({1'b0, {(DERIV_W-1){1'b1}}});
      else               deriv_d = qx[DERIV_W-1:0];
    end
  end

  // Floor to integer and clamp; the lower limit is tested first
  assign u_full = acc_q >>> FRAC_GAIN;
  assign lo_ext = ACW'(drive_min_i);
  assign hi_ext = ACW'(drive_max_i);
  always_comb begin
    if (u_full < lo_ext) begin
      drive_d   = drive_min_i;
      clamped_d = 1'b1;
    end else if (u_full > hi_ext) begin
      drive_d   = drive_max_i;
      clamped_d = 1'b1;
    end else begin
      drive_d   = u_full[DRIVE_W-1:0];
      clamped_d = 1'b0;
    end
  end

  // Controller state: cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else begin
      if (cmd_i.int_upd) begin
        if (isum > IntegMax)      integ_q <= IntegMax[INTEG_W-1:0];
        else if (isum < IntegMin) integ_q <= IntegMin[INTEG_W-1:0];
        else                      integ_q <= isum[INTEG_W-1:0];
      end
      if (cmd_i.out_load) last_q <= error_q;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load)         error_q   <= EW'(target_speed_i) - EW'(measured_speed_i);
    if (cmd_i.div_start)    div_neg_q <= diff[EW];
    if (cmd_i.deriv_load)   deriv_q   <= deriv_d;
    if (cmd_i.tmp_load)     tmp_q     <= TW'(prod_q);
    if (cmd_i.tmp_add)      tmp_q     <= tmp_q + (TW'(prod_q) <<< INTEG_HALF);
    if (cmd_i.acc_init)     acc_q     <= ACW'(prod_q);
    if (cmd_i.acc_add_tmp)  acc_q     <= acc_q + ACW'(tmp_q >>> FRAC_TIME);
    if (cmd_i.acc_add_prod) acc_q     <= acc_q + ACW'(prod_q);
    if (cmd_i.out_load) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign drive_o   = drive_q;
  assign clamped_o = clamped_q;

endmodule

>>> rtl/psc_ctrl.sv
// Sequencer of the PID speed controller: steps the datapath through one sample.
// Depends on psc_pkg.
module psc_ctrl import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  psc_status_t status_i,
  output psc_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_INT,
    ST_KP,
    ST_KILO,
    ST_KIHI,
    ST_KIADD,
    ST_WAIT,
    ST_KD,
    ST_KDADD,
    ST_OUT
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  psc_cmd_t cmd;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_KD;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.div_start = 1'b1;
        cmd.mul_sel   = MUL_ERR_PERIOD;
        state_d       = ST_INT;
      end
      ST_INT: begin
        cmd.int_upd = 1'b1;
        cmd.mul_sel = MUL_KP;
        state_d     = ST_KP;
      end
      ST_KP: begin
        cmd.acc_init = 1'b1;
        cmd.mul_sel  = MUL_KI_LO;
        state_d      = ST_KILO;
      end
      ST_KILO: begin
        cmd.tmp_load = 1'b1;
        cmd.mul_sel  = MUL_KI_HI;
        state_d      = ST_KIHI;
      end
      ST_KIHI: begin
        cmd.tmp_add = 1'b1;
        state_d     = ST_KIADD;
      end
      ST_KIADD: begin
        cmd.acc_add_tmp = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (!status_i.div_busy) begin
          cmd.deriv_load = 1'b1;
          state_d        = ST_KD;
        end
      end
      ST_KD: begin
        cmd.mul_sel = MUL_KD;
        state_d     = ST_KDADD;
      end
      ST_KDADD: begin
        cmd.acc_add_prod = 1'b1;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

>>> rtl/pid_speed_controller_top.sv
// PID speed controller, top level. Depends on psc_pkg, the psc interfaces,
// psc_regs, psc_ctrl and psc_datapath.
// A sample is taken only when the sequencer is idle, so the next sample waits until
// the result of the last one is loaded; the pace is set by the derivative divider,
// which makes one quotient bit per cycle over SPEED_WIDTH+18 bits.
// Reset (rst_ni low, asynchronous) clears the integral and the previous error and
// loads the register defaults; the block takes samples as soon as reset is released.
module pid_speed_controller_top import psc_pkg::*; #(
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  psc_sample_if.sink   sample_i,
  psc_result_if.source result_o,
  psc_cfg_if.sink      cfg_i
);

  localparam int CfgWidth = (SPEED_WIDTH > GAIN_W) ? SPEED_WIDTH : GAIN_W;

  // Register file outputs
  logic signed [GAIN_W-1:0]      gain_p, gain_i, gain_d;
  logic signed [SPEED_WIDTH-1:0] target_speed;
  logic [PERIOD_W-1:0]           sample_period;
  logic signed [DRIVE_W-1:0]     drive_min, drive_max;

  // Sequencer <-> datapath
  psc_cmd_t    cmd;
  psc_status_t status;
  logic        in_ready;
  logic        out_valid;

  // Config writes land in the register file; the port never stalls.
  psc_regs #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .CFG_WIDTH   (CfgWidth)
  ) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_i),
    .gain_p_o        (gain_p),
    .gain_i_o        (gain_i),
    .gain_d_o        (gain_d),
    .target_speed_o  (target_speed),
    .sample_period_o (sample_period),
    .drive_min_o     (drive_min),
    .drive_max_o     (drive_max)
  );

  // The sequencer takes a sample only when idle, but a finished result may
  // still sit in the output register waiting for its transfer meanwhile.
  psc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath shares one 17-bit-by-wide multiplier across the error*period,
  // proportional, split integral and derivative products; the divider runs
  // alongside those steps.
  psc_datapath #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .measured_speed_i (sample_i.measured_speed),
    .gain_p_i         (gain_p),
    .gain_i_i         (gain_i),
    .gain_d_i         (gain_d),
    .target_speed_i   (target_speed),
    .sample_period_i  (sample_period),
    .drive_min_i      (drive_min),
    .drive_max_i      (drive_max),
    .drive_o          (result_o.drive),
    .clamped_o        (result_o.clamped)
  );

  assign sample_i.ready = in_ready;
  assign result_o.valid = out_valid;

endmodule

>>> rtl/psc_checker.sv
// Port-level checks of the PID speed controller, bound to the top level.
// Depends on pid_speed_controller_top and its interfaces.
module psc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic sample_valid_i,
  input logic sample_ready_i,
  input logic result_valid_i,
  input logic result_ready_i,
  input logic [15:0] drive_i,
  input logic clamped_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = sample_valid_i && sample_ready_i;
  assign out_xfer = result_valid_i && result_ready_i;

  // Count samples taken whose result has not been transferred yet
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer)      pend_d = pend_q + 2'd1;
    else if (!in_xfer && out_xfer) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else         pend_q <= pend_d;
  end

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=>
      result_valid_i && $stable(drive_i) && $stable(clamped_i))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !sample_ready_i ##1 !sample_ready_i)
    else $error("sample taken while a sample is in work");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> pend_q != 2'd0)
    else $error("result without a sample");

  a_two_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !sample_ready_i)
    else $error("third sample accepted with a result waiting");

endmodule

bind pid_speed_controller_top psc_checker u_psc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_i.valid),
  .sample_ready_i (sample_i.ready),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .drive_i        (result_o.drive),
  .clamped_i      (result_o.clamped)
);

>>> tb/pid_speed_controller_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_speed_controller_top: random speed samples in,
// predicted drive and clamp flag compared on every result transfer.
// Depends on psc_pkg, the psc channel interfaces and the RTL of the block.
module pid_speed_controller_top_test;
  import psc_pkg::*;

  localparam int SPEED_W           = SPEED_WIDTH_DEF;
  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 4;
  localparam int RANDOM_PHASES     = 10;
  localparam int SAMPLES_PER_PHASE = 200;
  localparam int QUIET_PHASE       = 6;
  localparam int HOLD_AFTER        = 700;
  localparam int HOLD_OFF_CYCLES   = 600;
  localparam int DRAIN_CYCLES      = 60;
  localparam int MAX_REPORTS       = 200;

  // Index past the register file; a write there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

  // Saturation bounds of the integral and derivative terms.
  localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint DERIV_HI = (longint'(1) <<< (DERIV_W - 1)) - 1;
  localparam longint DERIV_LO = -DERIV_HI - 1;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } drive_result_t;

  // Clock and reset; reset is held low from time zero.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  psc_sample_if #(.Width(SPEED_W)) sample_bus ();
  psc_result_if                    result_bus ();
  psc_cfg_if #(.DataWidth(GAIN_W)) cfg_bus ();

  // Every block input is a testbench variable with a known value at time zero.
  logic                      smp_valid = 1'b0;
  logic signed [SPEED_W-1:0] smp_speed = '0;
  logic                      res_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [GAIN_W-1:0]         cfg_data  = '0;

  assign sample_bus.valid          = smp_valid;
  assign sample_bus.measured_speed = smp_speed;
  assign result_bus.ready          = res_ready;
  assign cfg_bus.valid             = cfg_valid;
  assign cfg_bus.index             = cfg_index;
  assign cfg_bus.data              = cfg_data;

  pid_speed_controller_top #(.SPEED_WIDTH(SPEED_W)) dut (
    .clk_i,
    .rst_ni,
    .sample_i (sample_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // Controller copy: register values as last written, plus loop state.
  logic signed [GAIN_W-1:0]  gain_p_m    = GAIN_RST;
  logic signed [GAIN_W-1:0]  gain_i_m    = GAIN_RST;
  logic signed [GAIN_W-1:0]  gain_d_m    = GAIN_RST;
  logic signed [SPEED_W-1:0] target_m    = '0;
  logic [PERIOD_W-1:0]       period_m    = PERIOD_RST;
  logic signed [DRIVE_W-1:0] drive_min_m = DRIVE_MIN_RST;
  logic signed [DRIVE_W-1:0] drive_max_m = DRIVE_MAX_RST;
  longint                    integ_acc   = 0;
  longint                    prev_err    = 0;

  logic signed [SPEED_W-1:0] pending_speeds[$];
  drive_result_t             expected_drives[$];

  logic hold_off = 1'b0;  // receiver back-pressure window
  logic quiet    = 1'b0;  // phase with no idling on either side
  int   send_gap;
  int   stall_cnt;
  int   error_cnt    = 0;
  int   samples_sent = 0;
  int   drives_seen  = 0;
  int   clamps_seen  = 0;
  int   settings_cnt = 0;

  task automatic report_mismatch(input string what);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Mirror one register transfer; writes past the last index are dropped.
  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [GAIN_W-1:0] value);
    case (idx)
      REG_GAIN_P:        gain_p_m    = value;
      REG_GAIN_I:        gain_i_m    = value;
      REG_GAIN_D:        gain_d_m    = value;
      REG_TARGET_SPEED:  target_m    = value;
      REG_SAMPLE_PERIOD: period_m    = value;
      REG_DRIVE_MIN:     drive_min_m = value;
      REG_DRIVE_MAX:     drive_max_m = value;
      default: ;
    endcase
  endfunction

  // Advance the control loop by one sample and return the drive it produces.
  function automatic drive_result_t next_drive(input logic signed [SPEED_W-1:0] speed);
    longint kp, ki, kd, per, err, deriv, acc, u;
    drive_result_t r;
    kp  = gain_p_m;
    ki  = gain_i_m;
    kd  = gain_d_m;
    per = period_m;
    // A zero period behaves as the smallest period.
    if (per == 0) per = 1;
    err = longint'(target_m) - longint'(speed);

    integ_acc = integ_acc + err * per;
    if (integ_acc > INTEG_HI) integ_acc = INTEG_HI;
    if (integ_acc < INTEG_LO) integ_acc = INTEG_LO;

    // Division truncates toward zero, then saturates to the derivative width.
    deriv = ((err - prev_err) * 65536) / per;
    if (deriv > DERIV_HI) deriv = DERIV_HI;
    if (deriv < DERIV_LO) deriv = DERIV_LO;

    acc = kp * err + ((ki * integ_acc) >>> FRAC_TIME) + kd * deriv;
    u   = acc >>> FRAC_GAIN;

    // Lower limit wins when the limits are inverted.
    r.clamped = 1'b0;
    if (u < longint'(drive_min_m)) begin
      u = drive_min_m;
      r.clamped = 1'b1;
    end else if (u > longint'(drive_max_m)) begin
      u = drive_max_m;
      r.clamped = 1'b1;
    end
    prev_err = err;
    r.drive  = u[DRIVE_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, some medium, a few long ones.
  function automatic int pick_gap(input logic no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  // Register value in [lo, hi], biased toward the two ends.
  function automatic logic [GAIN_W-1:0] pick_reg(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0: return lo[GAIN_W-1:0];
      1: return hi[GAIN_W-1:0];
      default: return GAIN_W'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // Speed sample: often near the setpoint, else anywhere, sometimes at the rails.
  function automatic logic signed [SPEED_W-1:0] pick_speed();
    int v;
    case ($urandom_range(0, 9))
      0: v = int'(SPEED_MIN);
      1: v = int'(SPEED_MAX);
      2, 3, 4, 5: v = int'(target_m) + int'($urandom_range(0, 512)) - 256;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v < int'(SPEED_MIN)) v = int'(SPEED_MIN);
    if (v > int'(SPEED_MAX)) v = int'(SPEED_MAX);
    return v[SPEED_W-1:0];
  endfunction

  // Offer one register write and hold it until the transfer; the caller
  // drops valid after the last write of a batch.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    apply_reg(idx, value);
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                               input logic [GAIN_W-1:0] gd, input logic [GAIN_W-1:0] tgt,
                               input logic [GAIN_W-1:0] per, input logic [GAIN_W-1:0] lo,
                               input logic [GAIN_W-1:0] hi);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_TARGET_SPEED, tgt);
    write_reg(REG_SAMPLE_PERIOD, per);
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_DRIVE_MAX, hi);
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  // Wait until every queued sample is transferred and every drive has come back.
  // Check at the falling edge, where the driver and monitor updates have settled,
  // then resume on a rising edge.
  task automatic wait_drained();
    while (pending_speeds.size() != 0 || smp_valid || expected_drives.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Sample driver: on each transfer, predict the drive; then hold, idle or
  // advance to the next pending sample.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid <= 1'b0;
      smp_speed <= '0;
      send_gap  = 0;
    end else begin
      if (smp_valid && sample_bus.ready) begin
        expected_drives.push_back(next_drive(smp_speed));
        samples_sent++;
      end
      if (!smp_valid || sample_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          smp_valid <= 1'b0;
        end else if (pending_speeds.size() != 0) begin
          smp_valid <= 1'b1;
          smp_speed <= pending_speeds.pop_front();
          send_gap  = pick_gap(quiet);
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest prediction, then
  // pick the ready level for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_monitor
    drive_result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (res_ready && result_bus.valid) begin
        drives_seen++;
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("drive %0d with no sample outstanding", result_bus.drive));
        end else begin
          want = expected_drives.pop_front();
          if (want.clamped) clamps_seen++;
          if (result_bus.drive !== want.drive)
            report_mismatch($sformatf("drive %0d, predicted %0d", result_bus.drive, want.drive));
          if (result_bus.clamped !== want.clamped)
            report_mismatch($sformatf("clamp flag %b, predicted %b", result_bus.clamped,
                                      want.clamped));
        end
      end
      if (hold_off) begin
        res_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        stall_cnt = pick_gap(quiet);
      end
    end
  end

  // Back-pressure: once traffic is flowing, starve the result side long enough
  // for the block to fill up and stall the sample channel.
  initial begin : receiver_hold
    wait (samples_sent >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    logic [GAIN_W-1:0] gp, gi, gd, tgt, per, lim_a, lim_b, lo, hi;
    logic              wide;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: zero gains give a zero drive at any speed.
    pending_speeds.push_back(SPEED_MAX);
    pending_speeds.push_back(SPEED_MIN);
    pending_speeds.push_back('0);
    wait_drained();

    // Unity proportional gain; the most negative speed overruns the upper limit.
    load_settings(16'h0100, '0, '0, '0, PERIOD_RST, DRIVE_MIN_RST, DRIVE_MAX_RST);
    pending_speeds.push_back(SPEED_MIN);
    pending_speeds.push_back(SPEED_MAX);
    wait_drained();

    // Extreme gains, setpoint and period with narrow symmetric limits.
    load_settings(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFC18, 16'h03E8);
    pending_speeds.push_back(SPEED_MIN);
    pending_speeds.push_back(SPEED_MAX);
    pending_speeds.push_back('0);
    pending_speeds.push_back(SPEED_MIN);
    wait_drained();

    // Zero period, derivative only: rail-to-rail swings saturate the derivative.
    load_settings('0, '0, 16'h7FFF, '0, '0, DRIVE_MIN_RST, DRIVE_MAX_RST);
    pending_speeds.push_back(SPEED_MAX);
    pending_speeds.push_back(SPEED_MIN);
    pending_speeds.push_back(SPEED_MAX);
    pending_speeds.push_back(SPEED_MIN);
    pending_speeds.push_back('0);
    wait_drained();

    // Inverted limits (lower above upper), plus a write past the register file.
    write_reg(REG_UNUSED, 16'hA5A5);
    load_settings(16'h0100, '0, '0, '0, PERIOD_RST, 16'h0064, 16'hFF9C);
    pending_speeds.push_back(-16'sd1000);
    pending_speeds.push_back(16'sd1000);
    pending_speeds.push_back('0);
    wait_drained();

    // Random phases: new settings each time, loop state carried over.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      quiet <= (k == QUIET_PHASE);
      wide  = ($urandom_range(0, 3) == 0);
      gp = wide ? pick_reg(-32768, 32767) : pick_reg(-1024, 1024);
      gi = wide ? pick_reg(-32768, 32767) : pick_reg(-64, 64);
      gd = wide ? pick_reg(-32768, 32767) : pick_reg(-64, 64);
      tgt = ($urandom_range(0, 3) == 0) ? '0 : pick_reg(-32768, 32767);
      case ($urandom_range(0, 4))
        0: per = '0;
        1: per = 16'd1;
        2: per = 16'hFFFF;
        3: per = PERIOD_RST;
        default: per = pick_reg(1, 65535);
      endcase
      lim_a = pick_reg(-32768, 32767);
      lim_b = pick_reg(-32768, 32767);
      case ($urandom_range(0, 3))
        0: begin
          lo = DRIVE_MIN_RST;
          hi = DRIVE_MAX_RST;
        end
        1: begin
          // Inverted order.
          lo = ($signed(lim_a) > $signed(lim_b)) ? lim_a : lim_b;
          hi = ($signed(lim_a) > $signed(lim_b)) ? lim_b : lim_a;
        end
        default: begin
          lo = ($signed(lim_a) < $signed(lim_b)) ? lim_a : lim_b;
          hi = ($signed(lim_a) < $signed(lim_b)) ? lim_b : lim_a;
        end
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, GAIN_W'($urandom_range(0, 65535)));
      load_settings(gp, gi, gd, tgt, per, lo, hi);
      for (int i = 0; i < SAMPLES_PER_PHASE; i++) pending_speeds.push_back(pick_speed());
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d drive results from %0d speed samples over %0d register settings.",
             drives_seen, samples_sent, settings_cnt);
    $display("%0d results were limited; zero period, inverted limits and back-pressure ran.",
             clamps_seen);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("Timeout: stimulus or results stalled.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
